@@ hw/rtl/nat_header_rewrite_checksum_assert.svh @@
// Assertion macros used by the NAT header rewrite top level, nat_header_rewrite_checksum.
// Define NO_ASSERTIONS to compile every use of these macros to nothing.
`ifndef NAT_HEADER_REWRITE_CHECKSUM_ASSERT_SVH
`define NAT_HEADER_REWRITE_CHECKSUM_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define NHRC_ASSERT_IMPLY(name, clock, resetn, pre, post, msg) \
    name: assert property (@(posedge clock) disable iff (!(resetn)) \
        (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define NHRC_ASSERT_NEXT(name, clock, resetn, pre, post, msg) \
    name: assert property (@(posedge clock) disable iff (!(resetn)) \
        (pre) |=> (post)) else $error(msg);

`else

`define NHRC_ASSERT_IMPLY(name, clock, resetn, pre, post, msg)
`define NHRC_ASSERT_NEXT(name, clock, resetn, pre, post, msg)

`endif

`endif

@@ hw/rtl/nhrc_pkg.sv @@
// Types, codes and helper functions for the NAT header rewrite block.
// Used by every nhrc_* module and by nat_header_rewrite_checksum.
package nhrc_pkg;

    localparam int SUM_W       = 21;
    localparam int PATCH_SLOTS = 4;
    localparam int IN_DATA_W   = 288;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 128;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    typedef logic [1:0] req_kind_t;

    localparam req_kind_t REQ_DNAT  = 2'd0;
    localparam req_kind_t REQ_SNAT  = 2'd1;
    localparam req_kind_t REQ_REPLY = 2'd2;

    // One header as it sits in the input register
    typedef struct packed {
        req_kind_t   req_type;
        logic [63:0] hdr_front;
        logic [15:0] ttl_protocol;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] l4_checksum;
        logic [31:0] new_addr_a;
        logic [31:0] new_addr_b;
        logic [15:0] new_port_a;
        logic [15:0] new_port_b;
    } hdr_t;

    // Rewritten addresses and ports
    typedef struct packed {
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
    } rw_t;

    // Incremental checksum updates: one old/new 32-bit word pair per slot
    typedef struct packed {
        logic [PATCH_SLOTS-1:0]       en;
        logic [PATCH_SLOTS-1:0][31:0] old_word;
        logic [PATCH_SLOTS-1:0][31:0] new_word;
    } patch_t;

    // One result item
    typedef struct packed {
        logic [15:0] out_l4_checksum;
        logic [15:0] out_dst_port;
        logic [15:0] out_src_port;
        logic [15:0] out_ip_checksum;
        logic [31:0] out_dst_addr;
        logic [31:0] out_src_addr;
    } res_t;

    // End-around carry fold of a wide one's-complement sum to 16 bits
    function automatic logic [15:0] fold16(input logic [SUM_W-1:0] s);
        logic [16:0] first;
        logic [15:0] second;
        first  = {1'b0, s[15:0]} + {12'd0, s[SUM_W-1:16]};
        second = first[15:0] + {15'd0, first[16]};
        return second;
    endfunction

endpackage

@@ hw/rtl/nhrc_rewrite.sv @@
// Address and port selection for the NAT kinds, plus checksum update words.
// Depends on nhrc_pkg.
module nhrc_rewrite (
    input  nhrc_pkg::hdr_t   hdr,
    output nhrc_pkg::rw_t    rw,
    output nhrc_pkg::patch_t patch
);

    logic [7:0] proto;
    logic       is_tcp;
    logic       is_l4;

    assign proto  = hdr.ttl_protocol[7:0];
    assign is_tcp = (proto == nhrc_pkg::PROTO_TCP);
    assign is_l4  = is_tcp || (proto == nhrc_pkg::PROTO_UDP);

    // Pick new fields and the words that leave and enter the L4 sum
    always_comb
    begin
        rw.saddr       = hdr.saddr;
        rw.daddr       = hdr.daddr;
        rw.sport       = hdr.sport;
        rw.dport       = hdr.dport;
        patch.en       = '0;
        patch.old_word = '0;
        patch.new_word = '0;
        unique case (hdr.req_type)
            nhrc_pkg::REQ_DNAT:
            begin
                rw.daddr = hdr.new_addr_a;
                if (is_l4)
                begin
                    rw.dport          = hdr.new_port_a;
                    patch.en          = 4'b0011;
                    patch.old_word[0] = hdr.daddr;
                    patch.new_word[0] = hdr.new_addr_a;
                    patch.old_word[1] = {hdr.sport, hdr.dport};
                    patch.new_word[1] = {hdr.sport, hdr.new_port_a};
                end
            end
            nhrc_pkg::REQ_SNAT:
            begin
                rw.saddr = hdr.new_addr_a;
                if (is_l4)
                begin
                    rw.sport          = hdr.new_port_a;
                    patch.en          = 4'b0011;
                    patch.old_word[0] = hdr.saddr;
                    patch.new_word[0] = hdr.new_addr_a;
                    patch.old_word[1] = {hdr.sport, hdr.dport};
                    patch.new_word[1] = {hdr.new_port_a, hdr.dport};
                end
            end
            nhrc_pkg::REQ_REPLY:
            begin
                rw.saddr = hdr.new_addr_a;
                rw.daddr = hdr.new_addr_b;
                // UDP reply keeps ports and L4 checksum as they are
                if (is_tcp)
                begin
                    rw.sport          = hdr.new_port_a;
                    rw.dport          = hdr.new_port_b;
                    patch.en          = 4'b1111;
                    patch.old_word[0] = hdr.saddr;
                    patch.new_word[0] = hdr.new_addr_a;
                    patch.old_word[1] = hdr.daddr;
                    patch.new_word[1] = hdr.new_addr_b;
                    patch.old_word[2] = {hdr.sport, hdr.dport};
                    patch.new_word[2] = {hdr.new_port_a, hdr.dport};
                    patch.old_word[3] = {hdr.new_port_a, hdr.dport};
                    patch.new_word[3] = {hdr.new_port_a, hdr.new_port_b};
                end
            end
            default:
            begin
                // unused kind: rewrite nothing
                patch.en = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/nhrc_l4_patch.sv @@
// Incremental L4 checksum update over up to four word changes.
// Depends on nhrc_pkg.
module nhrc_l4_patch (
    input  nhrc_pkg::patch_t patch,
    input  logic [15:0]      chk_in,
    output logic [15:0]      chk_out
);

    logic [nhrc_pkg::SUM_W-1:0] sum;

    // Chained updates collapse into one sum: each intermediate checksum is
    // complemented straight back, so only the final fold is needed
    always_comb
    begin
        sum = {5'd0, ~chk_in};
        for (int i = 0; i < nhrc_pkg::PATCH_SLOTS; i++)
        begin
            if (patch.en[i])
            begin
                sum = sum + {5'd0, ~patch.old_word[i][31:16]}
                          + {5'd0, ~patch.old_word[i][15:0]}
                          + {5'd0, patch.new_word[i][31:16]}
                          + {5'd0, patch.new_word[i][15:0]};
            end
        end
    end

    // Pass the checksum through when no word changes
    assign chk_out = (|patch.en) ? ~nhrc_pkg::fold16(sum) : chk_in;

endmodule

@@ hw/rtl/nhrc_ip_csum.sv @@
// IPv4 header checksum over twenty bytes, checksum field taken as zero.
// Depends on nhrc_pkg.
module nhrc_ip_csum (
    input  logic [63:0] hdr_front,
    input  logic [15:0] ttl_protocol,
    input  logic [31:0] saddr,
    input  logic [31:0] daddr,
    output logic [15:0] checksum
);

    logic [nhrc_pkg::SUM_W-1:0] sum;

    // Add the nine header words other than the checksum field
    always_comb
    begin
        sum = {5'd0, ttl_protocol}
            + {5'd0, saddr[31:16]} + {5'd0, saddr[15:0]}
            + {5'd0, daddr[31:16]} + {5'd0, daddr[15:0]};
        for (int i = 0; i < 4; i++)
        begin
            sum = sum + {5'd0, hdr_front[16*i +: 16]};
        end
    end

    assign checksum = ~nhrc_pkg::fold16(sum);

endmodule

@@ hw/rtl/nat_header_rewrite_checksum.sv @@
// Top level of the NAT header rewrite block: input register, rewrite
// logic, result register. Depends on nhrc_pkg, nhrc_rewrite, nhrc_ip_csum,
// nhrc_l4_patch and nat_header_rewrite_checksum_assert.svh.
//
// Use: one IPv4 header item (no options) with L4 ports, L4 checksum, a NAT
// kind on s_tuser and the new addresses and ports enters on the s_ channel.
// One result item leaves on the m_ channel with rewritten addresses and
// ports, a recomputed IPv4 header checksum and an incrementally updated L4
// checksum.
// Path: an accepted item is held in the input register, then moves into the
// result register, where it raises m_tvalid. Throughput: one item per cycle
// while m_tready is not low; the rewrite and both checksum adder trees sit
// between the two registers.
// Stall: while m_tready is low the result register holds its item; the
// input register still takes one more item, and s_tready drops only when
// both registers are full.
// Reset: rst_n clears both valid flags; no item is in flight afterwards.
`include "nat_header_rewrite_checksum_assert.svh"

module nat_header_rewrite_checksum (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // hdr_front, ttl_protocol, saddr, daddr, sport, dport,
    // l4_checksum, new_addr_a, new_addr_b, new_port_a, new_port_b
    input  logic [nhrc_pkg::IN_DATA_W-1:0]     s_tdata,
    // req_type
    input  logic [nhrc_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_src_addr, out_dst_addr, out_ip_checksum, out_src_port,
    // out_dst_port, out_l4_checksum
    output logic [nhrc_pkg::OUT_DATA_W-1:0]    m_tdata
);

    logic             stage_valid_reg;
    logic             stage_valid_next;
    nhrc_pkg::hdr_t   hdr_reg;
    nhrc_pkg::hdr_t   hdr_in;
    logic             out_valid_reg;
    logic             out_valid_next;
    nhrc_pkg::res_t   res_reg;
    nhrc_pkg::res_t   res_next;
    nhrc_pkg::rw_t    rw;
    nhrc_pkg::patch_t patch;
    logic [15:0]      ip_chk;
    logic [15:0]      l4_chk;
    logic             advance;
    logic             in_fire;
    logic             stage_l4;

    // Handshake: result register frees when empty or taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !stage_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    // Unpack the input item
    always_comb
    begin
        hdr_in.req_type     = s_tuser;
        hdr_in.hdr_front    = s_tdata[63:0];
        hdr_in.ttl_protocol = s_tdata[79:64];
        hdr_in.saddr        = s_tdata[111:80];
        hdr_in.daddr        = s_tdata[143:112];
        hdr_in.sport        = s_tdata[159:144];
        hdr_in.dport        = s_tdata[175:160];
        hdr_in.l4_checksum  = s_tdata[191:176];
        hdr_in.new_addr_a   = s_tdata[223:192];
        hdr_in.new_addr_b   = s_tdata[255:224];
        hdr_in.new_port_a   = s_tdata[271:256];
        hdr_in.new_port_b   = s_tdata[287:272];
    end

    // Advance the valid flags
    always_comb
    begin
        if (in_fire)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
        out_valid_next = advance ? stage_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Hold payload unless a new item moves in
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hdr_reg <= hdr_in;
        end
        if (advance && stage_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    nhrc_rewrite u_rewrite (
        .hdr   (hdr_reg),
        .rw    (rw),
        .patch (patch)
    );

    nhrc_ip_csum u_ip_csum (
        .hdr_front    (hdr_reg.hdr_front),
        .ttl_protocol (hdr_reg.ttl_protocol),
        .saddr        (rw.saddr),
        .daddr        (rw.daddr),
        .checksum     (ip_chk)
    );

    nhrc_l4_patch u_l4_patch (
        .patch   (patch),
        .chk_in  (hdr_reg.l4_checksum),
        .chk_out (l4_chk)
    );

    // Assemble the result item
    always_comb
    begin
        res_next.out_src_addr    = rw.saddr;
        res_next.out_dst_addr    = rw.daddr;
        res_next.out_ip_checksum = ip_chk;
        res_next.out_src_port    = rw.sport;
        res_next.out_dst_port    = rw.dport;
        res_next.out_l4_checksum = l4_chk;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

    assign stage_l4 = (hdr_reg.ttl_protocol[7:0] == nhrc_pkg::PROTO_TCP) ||
                      (hdr_reg.ttl_protocol[7:0] == nhrc_pkg::PROTO_UDP);

    // Checks on the two-register pipeline
    `NHRC_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !stage_valid_reg, s_tready, "input register empty but not ready")
    `NHRC_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_fire, stage_valid_reg, "accepted item lost from input register")
    `NHRC_ASSERT_NEXT(a_stage_moves, clk, rst_n, stage_valid_reg && advance, m_tvalid, "item dropped between registers")
    `NHRC_ASSERT_NEXT(a_non_l4_ports, clk, rst_n, stage_valid_reg && advance && !stage_l4, (res_reg.out_src_port == $past(hdr_reg.sport)) && (res_reg.out_l4_checksum == $past(hdr_reg.l4_checksum)), "non-L4 item had ports or checksum changed")

endmodule

@@ sim/tb_nat_header_rewrite_checksum.sv @@
// Testbench for nat_header_rewrite_checksum: directed and random headers, with
// expected results from a behavioural NAT rewrite and checksum predictor.
// Depends on nhrc_pkg and the nat_header_rewrite_checksum RTL only.
module tb_nat_header_rewrite_checksum;

    // Request kind that the block leaves without any rewrite
    localparam nhrc_pkg::req_kind_t REQ_NONE = 2'd3;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    localparam int RANDOM_HEADERS = 1300;
    localparam int STALL_LIMIT    = 1000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int IDLE_PERCENT   = 34;

    typedef struct {
        nhrc_pkg::hdr_t h;
        bit             drain;
    } hdr_item_t;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [nhrc_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic [nhrc_pkg::IN_USER_W-1:0]  s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [nhrc_pkg::OUT_DATA_W-1:0] m_tdata;

    hdr_item_t      pending_headers[$];
    nhrc_pkg::res_t expected_rewrites[$];
    hdr_item_t      on_bus;
    int             headers_sent = 0;
    int             mismatches   = 0;
    int             stall_cycles = 0;
    bit             hold_back;
    logic           steady;

    always #2 clk = ~clk;

    nat_header_rewrite_checksum DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Run both sides flat out for a stretch in the middle
    assign steady = (headers_sent >= 500) && (headers_sent < 800);

    // End-around carry fold to 16 bits
    function automatic logic [15:0] ones_fold(logic [31:0] s);
        s = {16'd0, s[15:0]} + (s >> 16);
        s = {16'd0, s[15:0]} + (s >> 16);
        return s[15:0];
    endfunction

    // Incremental checksum update: old word leaves, new word enters
    function automatic logic [15:0] csum_patch(logic [15:0] chk, logic [31:0] old_w,
                                               logic [31:0] new_w);
        logic [31:0] inv;
        logic [31:0] s;
        inv = ~old_w;
        s = {16'd0, ~chk};
        s += {16'd0, inv[31:16]};
        s += {16'd0, inv[15:0]};
        s += {16'd0, new_w[31:16]};
        s += {16'd0, new_w[15:0]};
        return ~ones_fold(s);
    endfunction

    // Full IPv4 header checksum with the checksum field taken as zero
    function automatic logic [15:0] ipv4_csum(logic [63:0] front, logic [15:0] ttlp,
                                              logic [31:0] sa, logic [31:0] da);
        logic [31:0] s;
        s = 32'd0;
        for (int i = 0; i < 4; i++)
            s += {16'd0, front[16*i +: 16]};
        s += {16'd0, ttlp};
        s += {16'd0, sa[31:16]} + {16'd0, sa[15:0]};
        s += {16'd0, da[31:16]} + {16'd0, da[15:0]};
        return ~ones_fold(s);
    endfunction

    // Rewrite one header and work out both checksums
    function automatic nhrc_pkg::res_t predict_rewrite(nhrc_pkg::hdr_t h);
        nhrc_pkg::res_t r;
        logic [7:0]     proto;
        logic           has_ports;
        logic [31:0]    mid_word;
        logic [15:0]    chk;
        proto     = h.ttl_protocol[7:0];
        has_ports = (proto == nhrc_pkg::PROTO_TCP) || (proto == nhrc_pkg::PROTO_UDP);
        r.out_src_addr = h.saddr;
        r.out_dst_addr = h.daddr;
        r.out_src_port = h.sport;
        r.out_dst_port = h.dport;
        chk = h.l4_checksum;
        case (h.req_type)
            nhrc_pkg::REQ_DNAT:
            begin
                r.out_dst_addr = h.new_addr_a;
                if (has_ports)
                begin
                    r.out_dst_port = h.new_port_a;
                    chk = csum_patch(chk, h.daddr, h.new_addr_a);
                    chk = csum_patch(chk, {h.sport, h.dport},
                                     {h.sport, h.new_port_a});
                end
            end
            nhrc_pkg::REQ_SNAT:
            begin
                r.out_src_addr = h.new_addr_a;
                if (has_ports)
                begin
                    r.out_src_port = h.new_port_a;
                    chk = csum_patch(chk, h.saddr, h.new_addr_a);
                    chk = csum_patch(chk, {h.sport, h.dport},
                                     {h.new_port_a, h.dport});
                end
            end
            nhrc_pkg::REQ_REPLY:
            begin
                r.out_src_addr = h.new_addr_a;
                r.out_dst_addr = h.new_addr_b;
                // ports and L4 checksum only for TCP; UDP passes them through
                if (proto == nhrc_pkg::PROTO_TCP)
                begin
                    chk = csum_patch(chk, h.saddr, h.new_addr_a);
                    chk = csum_patch(chk, h.daddr, h.new_addr_b);
                    mid_word = {h.new_port_a, h.dport};
                    chk = csum_patch(chk, {h.sport, h.dport}, mid_word);
                    chk = csum_patch(chk, mid_word, {h.new_port_a, h.new_port_b});
                    r.out_src_port = h.new_port_a;
                    r.out_dst_port = h.new_port_b;
                end
            end
            default:
            begin
            end
        endcase
        r.out_l4_checksum = chk;
        r.out_ip_checksum = ipv4_csum(h.hdr_front, h.ttl_protocol,
                                      r.out_src_addr, r.out_dst_addr);
        return r;
    endfunction

    function automatic logic [nhrc_pkg::IN_DATA_W-1:0] pack_header(nhrc_pkg::hdr_t h);
        return {h.new_port_b, h.new_port_a, h.new_addr_b, h.new_addr_a, h.l4_checksum,
                h.dport, h.sport, h.daddr, h.saddr, h.ttl_protocol,
                h.hdr_front};
    endfunction

    // Random header of a given kind and protocol, sometimes with corner values
    function automatic nhrc_pkg::hdr_t random_header(nhrc_pkg::req_kind_t kind,
                                                     logic [7:0] proto);
        nhrc_pkg::hdr_t h;
        h.req_type     = kind;
        h.hdr_front    = {$urandom, $urandom};
        h.ttl_protocol = {8'($urandom), proto};
        h.saddr        = $urandom;
        h.daddr        = $urandom;
        h.sport        = 16'($urandom);
        h.dport        = 16'($urandom);
        h.l4_checksum  = 16'($urandom);
        h.new_addr_a   = $urandom;
        h.new_addr_b   = $urandom;
        h.new_port_a   = 16'($urandom);
        h.new_port_b   = 16'($urandom);
        if ($urandom_range(7) == 0)
        begin
            h.new_addr_a = (kind == nhrc_pkg::REQ_DNAT) ? h.daddr : h.saddr;
            h.new_addr_b = h.daddr;
            h.new_port_a = (kind == nhrc_pkg::REQ_DNAT) ? h.dport : h.sport;
            h.new_port_b = h.dport;
        end
        if ($urandom_range(9) == 0)
            h.l4_checksum = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        return h;
    endfunction

    function automatic void queue_header(nhrc_pkg::hdr_t h, bit drain);
        hdr_item_t it;
        it.h     = h;
        it.drain = drain;
        pending_headers.push_back(it);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Driver: present queued headers, record the expected rewrite on accept
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_rewrites.push_back(predict_rewrite(on_bus.h));
                headers_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                hold_back = !steady && ($urandom_range(99) < IDLE_PERCENT);
                if (pending_headers.size() != 0 && !hold_back &&
                    !(pending_headers[0].drain && expected_rewrites.size() != 0))
                begin
                    on_bus   = pending_headers.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= pack_header(on_bus.h);
                    s_tuser  <= on_bus.h.req_type;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expected rewrite
    always @(posedge clk or negedge rst_n)
    begin
        nhrc_pkg::res_t got;
        nhrc_pkg::res_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_rewrites.size() == 0)
                begin
                    $display("%0t: result with nothing expected: expected none got %h",
                             $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_rewrites.pop_front();
                    check_field("out_src_addr", want.out_src_addr, got.out_src_addr);
                    check_field("out_dst_addr", want.out_dst_addr, got.out_dst_addr);
                    check_field("out_ip_checksum", 32'(want.out_ip_checksum),
                                32'(got.out_ip_checksum));
                    check_field("out_src_port", 32'(want.out_src_port),
                                32'(got.out_src_port));
                    check_field("out_dst_port", 32'(want.out_dst_port),
                                32'(got.out_dst_port));
                    check_field("out_l4_checksum", 32'(want.out_l4_checksum),
                                32'(got.out_l4_checksum));
                end
            end
            m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog: count cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Stimulus, reset and end of run
    initial
    begin
        nhrc_pkg::hdr_t      h;
        nhrc_pkg::req_kind_t kind;
        logic [7:0]          proto;
        int                  pick;

        // every kind against TCP, UDP and a protocol without ports
        for (int k = 0; k < 4; k++)
        begin
            queue_header(random_header(nhrc_pkg::req_kind_t'(k), nhrc_pkg::PROTO_TCP), 1'b0);
            queue_header(random_header(nhrc_pkg::req_kind_t'(k), nhrc_pkg::PROTO_UDP), 1'b0);
            queue_header(random_header(nhrc_pkg::req_kind_t'(k), PROTO_ICMP), 1'b0);
        end

        // all-zero header over TCP
        h = '0;
        h.ttl_protocol = {8'h00, nhrc_pkg::PROTO_TCP};
        queue_header(h, 1'b0);
        // all-ones header, protocol byte all ones
        h = '1;
        h.req_type = nhrc_pkg::REQ_REPLY;
        queue_header(h, 1'b0);
        // all ones over TCP and over UDP
        h.ttl_protocol = {8'hFF, nhrc_pkg::PROTO_TCP};
        queue_header(h, 1'b0);
        h.req_type = nhrc_pkg::REQ_SNAT;
        h.ttl_protocol = {8'hFF, nhrc_pkg::PROTO_UDP};
        queue_header(h, 1'b0);
        // UDP zero checksum gets patched like any other value, and so does a TCP checksum of FFFF
        h = random_header(nhrc_pkg::REQ_DNAT, nhrc_pkg::PROTO_UDP);
        h.l4_checksum = 16'h0000;
        queue_header(h, 1'b0);
        h = random_header(nhrc_pkg::REQ_SNAT, nhrc_pkg::PROTO_UDP);
        h.l4_checksum = 16'h0000;
        queue_header(h, 1'b0);
        h = random_header(nhrc_pkg::REQ_SNAT, nhrc_pkg::PROTO_TCP);
        h.l4_checksum = 16'hFFFF;
        queue_header(h, 1'b0);
        // reply over UDP: ports and L4 checksum pass through
        h = random_header(nhrc_pkg::REQ_REPLY, nhrc_pkg::PROTO_UDP);
        h.l4_checksum = 16'h0000;
        queue_header(h, 1'b0);
        // reply over TCP with nothing actually changed
        h = random_header(nhrc_pkg::REQ_REPLY, nhrc_pkg::PROTO_TCP);
        h.new_addr_a = h.saddr;
        h.new_addr_b = h.daddr;
        h.new_port_a = h.sport;
        h.new_port_b = h.dport;
        queue_header(h, 1'b0);
        // unused kind over TCP with all ones
        h = '1;
        h.req_type = REQ_NONE;
        h.ttl_protocol = {8'hFF, nhrc_pkg::PROTO_TCP};
        queue_header(h, 1'b0);
        // port extremes
        h = random_header(nhrc_pkg::REQ_DNAT, nhrc_pkg::PROTO_TCP);
        h.dport      = 16'h0000;
        h.new_port_a = 16'hFFFF;
        queue_header(h, 1'b0);

        // random headers, with a full drain now and then
        for (int i = 0; i < RANDOM_HEADERS; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                kind = nhrc_pkg::REQ_DNAT;
            else if (pick < 60)
                kind = nhrc_pkg::REQ_SNAT;
            else if (pick < 92)
                kind = nhrc_pkg::REQ_REPLY;
            else
                kind = REQ_NONE;
            pick = $urandom_range(99);
            if (pick < 40)
                proto = nhrc_pkg::PROTO_TCP;
            else if (pick < 75)
                proto = nhrc_pkg::PROTO_UDP;
            else
                proto = 8'($urandom);
            queue_header(random_header(kind, proto), (i % 400) == 0);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every header to go in and every result to come out
        @(posedge clk);
        while (!(pending_headers.size() == 0 && !s_tvalid && expected_rewrites.size() == 0)
               && stall_cycles < STALL_LIMIT)
            @(posedge clk);

        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_nat_header_rewrite_checksum: done, errors");
        end
        else
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);
            if (mismatches == 0)
                $display("tb_nat_header_rewrite_checksum: done, clean");
            else
                $display("tb_nat_header_rewrite_checksum: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/nhrc_pkg.sv
hw/rtl/nhrc_rewrite.sv
hw/rtl/nhrc_l4_patch.sv
hw/rtl/nhrc_ip_csum.sv
hw/rtl/nat_header_rewrite_checksum.sv
sim/tb_nat_header_rewrite_checksum.sv
